@@ rtl/mva_pkg.sv @@
// ----------------------------------------------------------------------------
// mva_pkg
// shared types and constants of the midi voice allocator
// ----------------------------------------------------------------------------
package mva_pkg;

    localparam int MASK_W  = 16;
    localparam int VOICE_W = 4;
    localparam int KIND_W  = 2;
    localparam int NOTE_W  = 7;
    localparam int VALUE_W = 14;

    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_EVENT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE_ON     = 2'd0,
        KIND_AFTERTOUCH  = 2'd1,
        KIND_PITCH_WHEEL = 2'd2,
        KIND_NOTE_EVENT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        logic is_frame;
        logic hit;
        logic last;
        logic pend_any;
    } t_dp_stat;

endpackage

@@ rtl/mva_if.sv @@
// ----------------------------------------------------------------------------
// mva_in_if / mva_out_if
// request and result channels of the midi voice allocator
// ----------------------------------------------------------------------------
interface mva_in_if
    import mva_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [MASK_W-1:0]  active_mask;
    logic [KIND_W-1:0]  event_kind;
    logic [NOTE_W-1:0]  note_number;
    logic [VALUE_W-1:0] event_value;

    modport source (
        output valid, mode, active_mask, event_kind, note_number, event_value,
        input  ready
    );
    modport sink (
        input  valid, mode, active_mask, event_kind, note_number, event_value,
        output ready
    );
endinterface

interface mva_out_if
    import mva_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VOICE_W-1:0] voice;
    logic [KIND_W-1:0]  out_kind;
    logic [NOTE_W-1:0]  out_note;
    logic [VALUE_W-1:0] out_value;
    logic [MASK_W-1:0]  voice_active;
    logic               last;

    modport source (
        output valid, voice, out_kind, out_note, out_value, voice_active, last,
        input  ready
    );
    modport sink (
        input  valid, voice, out_kind, out_note, out_value, voice_active, last,
        output ready
    );
endinterface

@@ rtl/midi_voice_allocator.sv @@
// ----------------------------------------------------------------------------
// midi_voice_allocator
// routes midi events to polyphonic voices, first free voice on note-on
//
//   channel   dir  payload                                        flow
//   i_req     in   mode, active_mask, event_kind, note_number,   valid/ready
//                  event_value
//   o_rsp     out  voice, out_kind, out_note, out_value,          valid/ready
//                  voice_active, last
//
// a frame-start request is taken in idle and needs no scan; an event is loaded,
// scanned, then gives up to 16 results, set by the pending-voice mask emptied
// one voice per cycle while o_rsp is ready, in increasing voice order
// reset: i_rst_n synchronous, clears masks, stored notes and the sequencer
// a stall on o_rsp holds the current result; no request is taken meanwhile
// ----------------------------------------------------------------------------
module midi_voice_allocator
    import mva_pkg::*;
#(
    parameter int VOICES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mva_in_if.sink    i_req,
    mva_out_if.source o_rsp
);

    localparam int NV = (VOICES < MASK_W) ? VOICES : MASK_W;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;

    mva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    mva_datapath #(
        .NV (NV)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_mode         (i_req.mode),
        .i_active_mask  (i_req.active_mask),
        .i_event_kind   (i_req.event_kind),
        .i_note_number  (i_req.note_number),
        .i_event_value  (i_req.event_value),
        .o_stat         (stat),
        .o_voice        (o_rsp.voice),
        .o_kind         (o_rsp.out_kind),
        .o_note         (o_rsp.out_note),
        .o_value        (o_rsp.out_value),
        .o_voice_active (o_rsp.voice_active)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.last  = stat.last;

`ifndef ASSERT_OFF
    a_valid_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> stat.pend_any)
        else $error("result shown with no pending voice");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> !o_rsp.valid)
        else $error("request taken while a result is pending");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready && o_rsp.last) |=> !o_rsp.valid)
        else $error("result after the last one of a request");

    a_pop_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready && !o_rsp.last) |=>
            (o_rsp.valid && (o_rsp.voice > $past(o_rsp.voice))))
        else $error("results not in increasing voice order");
`endif

endmodule

@@ rtl/mva_datapath.sv @@
// ----------------------------------------------------------------------------
// mva_datapath
// voice masks, stored notes, parallel note compare and result selection
// ----------------------------------------------------------------------------
module mva_datapath
    import mva_pkg::*;
#(
    parameter int NV = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic               i_mode,
    input  logic [MASK_W-1:0]  i_active_mask,
    input  logic [KIND_W-1:0]  i_event_kind,
    input  logic [NOTE_W-1:0]  i_note_number,
    input  logic [VALUE_W-1:0] i_event_value,
    output t_dp_stat           o_stat,
    output logic [VOICE_W-1:0] o_voice,
    output logic [KIND_W-1:0]  o_kind,
    output logic [NOTE_W-1:0]  o_note,
    output logic [VALUE_W-1:0] o_value,
    output logic [MASK_W-1:0]  o_voice_active
);

    localparam logic [MASK_W-1:0] VOICE_BITS =
        MASK_W'((17'd1 << NV) - 17'd1);

    logic [NOTE_W-1:0]  r_notes [NV];
    logic [MASK_W-1:0]  r_frame_mask;
    logic [MASK_W-1:0]  r_out_mask;
    logic [MASK_W-1:0]  r_pending;
    logic [KIND_W-1:0]  r_kind;
    logic [NOTE_W-1:0]  r_note;
    logic [VALUE_W-1:0] r_value;

    logic [MASK_W-1:0]  free_vec;
    logic [MASK_W-1:0]  free_low;
    logic [MASK_W-1:0]  match_vec;
    logic [MASK_W-1:0]  n_pending;
    logic [MASK_W-1:0]  pend_rest;
    logic [MASK_W-1:0]  pend_low;
    logic [VOICE_W-1:0] voice_idx;
    logic               note_on;
    logic               chan_wide;

    assign note_on   = (r_kind == KIND_NOTE_ON);
    assign chan_wide = (r_kind == KIND_AFTERTOUCH) || (r_kind == KIND_PITCH_WHEEL);

    // lowest voice inactive at frame start
    assign free_vec = ~r_frame_mask & VOICE_BITS;
    assign free_low = free_vec & MASK_W'(~free_vec + MASK_W'(1));

    always_comb begin
        match_vec = '0;
        for (int v = 0; v < NV; v++) begin
            match_vec[v] = r_frame_mask[v] && (chan_wide || (r_notes[v] == r_note));
        end
    end

    assign n_pending = note_on ? free_low : match_vec;
    assign pend_rest = r_pending & MASK_W'(r_pending - MASK_W'(1));
    assign pend_low  = r_pending & ~pend_rest;

    always_comb begin
        voice_idx = '0;
        for (int v = 0; v < MASK_W; v++) begin
            if (pend_low[v]) begin
                voice_idx = voice_idx | VOICE_W'(v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_frame_mask <= '0;
            r_out_mask   <= '0;
            for (int v = 0; v < NV; v++) begin
                r_notes[v] <= '0;
            end
        end else begin
            if (i_cmd.load && (i_mode == MODE_FRAME)) begin
                r_frame_mask <= i_active_mask & VOICE_BITS;
                r_out_mask   <= i_active_mask & VOICE_BITS;
            end
            if (i_cmd.scan) begin
                r_pending <= n_pending;
                if (note_on) begin
                    r_out_mask <= r_out_mask | free_low;
                    for (int v = 0; v < NV; v++) begin
                        if (free_low[v]) begin
                            r_notes[v] <= r_note;
                        end
                    end
                end
            end else if (i_cmd.pop) begin
                r_pending <= pend_rest;
            end
        end
    end

    // request payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_mode == MODE_EVENT)) begin
            r_kind  <= i_event_kind;
            r_note  <= i_note_number;
            r_value <= i_event_value;
        end
    end

    assign o_stat.is_frame = (i_mode == MODE_FRAME);
    assign o_stat.hit      = |n_pending;
    assign o_stat.last     = (pend_rest == '0);
    assign o_stat.pend_any = |r_pending;

    assign o_voice        = voice_idx;
    assign o_kind         = r_kind;
    assign o_note         = r_note;
    assign o_value        = r_value;
    assign o_voice_active = r_out_mask;

endmodule

@@ rtl/mva_ctrl.sv @@
// ----------------------------------------------------------------------------
// mva_ctrl
// sequencer: takes a request, scans the voices for an event, then hands out any results
// ----------------------------------------------------------------------------
module mva_ctrl
    import mva_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_ready,
    output logic     o_out_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !i_stat.is_frame) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_state = i_stat.hit ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_out_ready && i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.pop   = i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// checks the midi voice allocator against a predictor of its voice routing:
// directed frame starts and events first, then random frames of events, with
// random idling on both channels, a long receiver hold-off and a drain pause
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mva_pkg::*;

    localparam int VOICE_COUNT  = 16;
    localparam int NUM_VOICES   = (VOICE_COUNT < 16) ? VOICE_COUNT : 16;
    localparam logic [MASK_W-1:0] VOICE_BITS =
        (NUM_VOICES >= 16) ? 16'hFFFF : MASK_W'((1 << NUM_VOICES) - 1);
    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic               mode;
        logic [MASK_W-1:0]  mask;
        t_kind              kind;
        logic [NOTE_W-1:0]  note;
        logic [VALUE_W-1:0] value;
    } t_midi_req;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [KIND_W-1:0]  kind;
        logic [NOTE_W-1:0]  note;
        logic [VALUE_W-1:0] value;
        logic [MASK_W-1:0]  active;
        logic               last;
    } t_voice_route;

    class voice_route_scoreboard;
        logic [NOTE_W-1:0] note_of_voice [16];
        logic [MASK_W-1:0] frame_mask;
        logic [MASK_W-1:0] live_mask;
        t_voice_route      pending [$];
        int                errors;

        function new();
            foreach (note_of_voice[v]) note_of_voice[v] = '0;
            frame_mask = '0;
            live_mask  = '0;
            errors     = 0;
        endfunction

        // work out the routes that one accepted request causes
        function void note_request(t_midi_req r);
            t_voice_route route;
            int           hits [$];
            if (r.mode == MODE_FRAME) begin
                frame_mask = r.mask & VOICE_BITS;
                live_mask  = frame_mask;
                return;
            end
            route.kind  = r.kind;
            route.note  = r.note;
            route.value = r.value;
            if (r.kind == KIND_NOTE_ON) begin
                // first voice free at frame start, even if an earlier note-on took it
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (!frame_mask[v]) begin
                        note_of_voice[v] = r.note;
                        live_mask[v]     = 1'b1;
                        route.voice      = VOICE_W'(v);
                        route.active     = live_mask;
                        route.last       = 1'b1;
                        pending.push_back(route);
                        return;
                    end
                end
                return;
            end
            for (int v = 0; v < NUM_VOICES; v++) begin
                if (frame_mask[v] && (r.kind == KIND_AFTERTOUCH ||
                        r.kind == KIND_PITCH_WHEEL || note_of_voice[v] == r.note))
                    hits.push_back(v);
            end
            foreach (hits[i]) begin
                route.voice  = VOICE_W'(hits[i]);
                route.active = live_mask;
                route.last   = (i == hits.size() - 1);
                pending.push_back(route);
            end
        endfunction

        function void check_result(t_voice_route got);
            t_voice_route want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result v=%0d k=%0d n=%0d val=%0d act=%h last=%0d",
                         $time, got.voice, got.kind, got.note, got.value, got.active,
                         got.last);
                return;
            end
            want = pending.pop_front();
            if (got.voice !== want.voice || got.kind !== want.kind ||
                    got.note !== want.note || got.value !== want.value ||
                    got.active !== want.active || got.last !== want.last) begin
                errors++;
                $display("%0t: mismatch expected v=%0d k=%0d n=%0d val=%0d act=%h last=%0d",
                         $time, want.voice, want.kind, want.note, want.value, want.active,
                         want.last);
                $display("%0t:          actual   v=%0d k=%0d n=%0d val=%0d act=%h last=%0d",
                         $time, got.voice, got.kind, got.note, got.value, got.active,
                         got.last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mva_in_if  u_req_if ();
    mva_out_if u_rsp_if ();

    midi_voice_allocator #(
        .VOICES (VOICE_COUNT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req_if),
        .o_rsp   (u_rsp_if)
    );

    voice_route_scoreboard sb;
    int                    items_sent;
    bit                    hold_rx;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_midi_req frame_req(logic [MASK_W-1:0] mask);
        t_midi_req r;
        r.mode  = MODE_FRAME;
        r.mask  = mask;
        r.kind  = t_kind'($urandom_range(0, 3));
        r.note  = NOTE_W'($urandom);
        r.value = VALUE_W'($urandom);
        return r;
    endfunction

    function automatic t_midi_req event_req(t_kind kind, logic [NOTE_W-1:0] note,
                                            logic [VALUE_W-1:0] value);
        t_midi_req r;
        r.mode  = MODE_EVENT;
        r.mask  = MASK_W'($urandom);
        r.kind  = kind;
        r.note  = note;
        r.value = value;
        return r;
    endfunction

    task automatic offer(input t_midi_req r);
        int gap;
        u_req_if.valid       <= 1'b1;
        u_req_if.mode        <= r.mode;
        u_req_if.active_mask <= r.mask;
        u_req_if.event_kind  <= r.kind;
        u_req_if.note_number <= r.note;
        u_req_if.event_value <= r.value;
        @(posedge i_clk);
        while (!u_req_if.ready) @(posedge i_clk);
        items_sent++;
        gap = idle_len();
        if (gap > 0) begin
            u_req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // checked away from the rising edge so the monitor has seen every request
    task automatic wait_drained();
        do @(negedge i_clk); while (sb.pending.size() != 0);
    endtask

    // accepted requests and results, sampled at the edge that accepts them
    always @(posedge i_clk) begin
        t_midi_req    req;
        t_voice_route rsp;
        if (i_rst_n) begin
            if (u_req_if.valid && u_req_if.ready) begin
                req.mode  = u_req_if.mode;
                req.mask  = u_req_if.active_mask;
                req.kind  = t_kind'(u_req_if.event_kind);
                req.note  = u_req_if.note_number;
                req.value = u_req_if.event_value;
                sb.note_request(req);
            end
            if (u_rsp_if.valid && u_rsp_if.ready) begin
                rsp.voice  = u_rsp_if.voice;
                rsp.kind   = u_rsp_if.out_kind;
                rsp.note   = u_rsp_if.out_note;
                rsp.value  = u_rsp_if.out_value;
                rsp.active = u_rsp_if.voice_active;
                rsp.last   = u_rsp_if.last;
                sb.check_result(rsp);
            end
        end
    end

    // result side: stretches of ready, random stalls, one long hold-off
    initial begin
        int gap;
        u_rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_rx) begin
                u_rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            u_rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            gap = idle_len();
            if (gap > 0) begin
                u_rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [MASK_W-1:0] mask;
        logic [NOTE_W-1:0] note;
        t_kind             kind;
        int                burst;
        bit                held;
        bit                paused;

        sb         = new();
        items_sent = 0;
        hold_rx    = 1'b0;
        held       = 1'b0;
        paused     = 1'b0;

        i_rst_n              <= 1'b0;
        u_req_if.valid       <= 1'b0;
        u_req_if.mode        <= MODE_FRAME;
        u_req_if.active_mask <= '0;
        u_req_if.event_kind  <= KIND_NOTE_ON;
        u_req_if.note_number <= '0;
        u_req_if.event_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // events before any frame start: note-on lands on voice 0, others reach nobody
        offer(event_req(KIND_NOTE_ON, 7'd127, 14'h3FFF));
        offer(event_req(KIND_AFTERTOUCH, 7'd0, 14'd0));
        offer(event_req(KIND_NOTE_EVENT, 7'd127, 14'd1));
        // all voices busy: note-on is dropped, channel events reach all of them
        offer(frame_req(16'hFFFF));
        offer(event_req(KIND_NOTE_ON, 7'd64, 14'd100));
        offer(event_req(KIND_AFTERTOUCH, 7'd64, 14'h3FFF));
        offer(event_req(KIND_PITCH_WHEEL, 7'd0, 14'd0));
        offer(event_req(KIND_NOTE_EVENT, 7'd127, 14'd200));
        offer(event_req(KIND_NOTE_EVENT, 7'd1, 14'd201));
        // two note-ons in one frame pick the same voice
        offer(frame_req(16'h0000));
        offer(event_req(KIND_NOTE_ON, 7'd5, 14'd10));
        offer(event_req(KIND_NOTE_ON, 7'd6, 14'd11));
        offer(frame_req(16'h0001));
        offer(event_req(KIND_NOTE_ON, 7'd9, 14'd12));
        offer(frame_req(16'h0003));
        offer(event_req(KIND_NOTE_EVENT, 7'd9, 14'd13));
        offer(event_req(KIND_NOTE_EVENT, 7'd6, 14'd14));
        offer(frame_req(16'h7FFF));
        offer(event_req(KIND_NOTE_ON, 7'd0, 14'h2AAA));
        offer(frame_req(16'hAAAA));
        offer(event_req(KIND_AFTERTOUCH, 7'd33, 14'h1555));
        offer(event_req(KIND_NOTE_EVENT, 7'd0, 14'h3FFF));

        while (items_sent < RANDOM_ITEMS + 22) begin
            if (!held && items_sent > 160) begin
                held    = 1'b1;
                hold_rx = 1'b1;
            end
            if (!paused && items_sent > 320) begin
                paused = 1'b1;
                u_req_if.valid <= 1'b0;
                wait_drained();
                @(posedge i_clk);
            end
            case ($urandom_range(0, 9))
                0: mask = 16'hFFFF;
                1: mask = 16'h0000;
                2: mask = MASK_W'($urandom);
                // voices keep sounding, a few of them stop
                default: mask = sb.live_mask & ~MASK_W'($urandom & $urandom & $urandom);
            endcase
            offer(frame_req(mask));
            burst = $urandom_range(1, 8);
            repeat (burst) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any field value at all
                    offer(event_req(t_kind'($urandom_range(0, 3)), NOTE_W'($urandom),
                                    VALUE_W'($urandom)));
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: kind = KIND_NOTE_ON;
                        4:          kind = KIND_AFTERTOUCH;
                        5:          kind = KIND_PITCH_WHEEL;
                        default:    kind = KIND_NOTE_EVENT;
                    endcase
                    // a small pool of notes so that note events find their voices
                    if ($urandom_range(0, 4) != 0)
                        note = NOTE_W'($urandom_range(60, 67));
                    else
                        note = NOTE_W'($urandom_range(0, 127));
                    offer(event_req(kind, note, VALUE_W'($urandom)));
                end
            end
        end

        u_req_if.valid <= 1'b0;
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
